// ===== rtl/qsu_pkg.sv =====
// ----------------------------------------------------------------------------
// qsu_pkg
// Types and codes shared by the piece queue and stack unit.
// ----------------------------------------------------------------------------
package qsu_pkg;

    localparam int PIECE_W = 24;

    // Slots in each part; the count fields of t_res are sized for this value
    localparam int SLOTS = 16;

    // Operation codes
    localparam logic [2:0] OP_ENQ  = 3'd0;
    localparam logic [2:0] OP_DEQ  = 3'd1;
    localparam logic [2:0] OP_PUSH = 3'd2;
    localparam logic [2:0] OP_POP  = 3'd3;
    localparam logic [2:0] OP_Q2S  = 3'd4;
    localparam logic [2:0] OP_S2Q  = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_QFULL  = 3'd1;
    localparam logic [2:0] ST_QEMPTY = 3'd2;
    localparam logic [2:0] ST_SFULL  = 3'd3;
    localparam logic [2:0] ST_SEMPTY = 3'd4;

    typedef struct packed {
        logic [15:0] shape;
        logic [7:0]  color;
    } t_piece;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] piece_shape;
        logic [7:0]  piece_color;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_shape;
        logic [7:0]  out_color;
        logic [3:0]  queue_count;
        logic [4:0]  stack_count;
    } t_res;

    // Per-part control from the sequencer
    typedef struct packed {
        logic take;
        logic add;
    } t_part_ctl;

    // Per-part occupancy flags
    typedef struct packed {
        logic empty;
        logic full;
    } t_part_stat;

endpackage

// ===== rtl/qsu_queue.sv =====
// ----------------------------------------------------------------------------
// qsu_queue
// Circular queue with one spare slot; head piece is prefetched into a
// registered read port so it is ready for the next operation.
// ----------------------------------------------------------------------------
module qsu_queue #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qsu_pkg::t_part_ctl    i_ctl,
    input  qsu_pkg::t_piece       i_wdata,
    output qsu_pkg::t_piece       o_head,
    output qsu_pkg::t_part_stat   o_stat,
    output logic [3:0]            o_count
);
    import qsu_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST  = IW'(SLOTS - 1);
    localparam logic [IW:0]   SPAN  = (IW + 1)'(SLOTS);

    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [IW:0]   w_fill;
    t_piece        r_mem [SLOTS];
    t_piece        r_rd;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
        next_slot = (i == LAST) ? '0 : i + 1'b1;
    endfunction

    always_comb begin
        n_head = i_ctl.take ? next_slot(r_head) : r_head;
        n_tail = i_ctl.add  ? next_slot(r_tail) : r_tail;
        if (n_tail >= n_head) begin
            w_fill = {1'b0, n_tail} - {1'b0, n_head};
        end else begin
            w_fill = {1'b0, n_tail} + SPAN - {1'b0, n_head};
        end
    end

    assign o_stat.empty = (r_head == r_tail);
    assign o_stat.full  = (next_slot(r_tail) == r_head);
    assign o_count      = 4'(w_fill);
    assign o_head       = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // Prefetch the next head; forward a piece written to that slot this cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.add) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_ctl.add && (r_tail == n_head)) begin
            r_rd <= i_wdata;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

endmodule

// ===== rtl/qsu_stack.sv =====
// ----------------------------------------------------------------------------
// qsu_stack
// Stack of pieces; the top entry is prefetched into a registered read port.
// ----------------------------------------------------------------------------
module qsu_stack #(
    parameter int SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  qsu_pkg::t_part_ctl    i_ctl,
    input  qsu_pkg::t_piece       i_wdata,
    output qsu_pkg::t_piece       o_top,
    output qsu_pkg::t_part_stat   o_stat,
    output logic [4:0]            o_count
);
    import qsu_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW = $clog2(SLOTS + 1);
    localparam logic [DW-1:0] FULL_D = DW'(SLOTS);

    logic [DW-1:0] r_depth, n_depth;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;
    t_piece        r_mem [SLOTS];
    t_piece        r_rd;

    always_comb begin
        if (i_ctl.take) begin
            n_depth = r_depth - 1'b1;
        end else if (i_ctl.add) begin
            n_depth = r_depth + 1'b1;
        end else begin
            n_depth = r_depth;
        end
        w_waddr = r_depth[IW-1:0];
        w_raddr = IW'(n_depth - 1'b1);
    end

    assign o_stat.empty = (r_depth == '0);
    assign o_stat.full  = (r_depth == FULL_D);
    assign o_count      = 5'(n_depth);
    assign o_top        = r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // Prefetch the new top; a push always lands on it, so forward the data
    always_ff @(posedge i_clk) begin
        if (i_ctl.add) begin
            r_mem[w_waddr] <= i_wdata;
        end
        if (i_ctl.add && (w_waddr == w_raddr)) begin
            r_rd <= i_wdata;
        end else begin
            r_rd <= r_mem[w_raddr];
        end
    end

endmodule

// ===== rtl/piece_queue_and_stack_unit.sv =====
// ----------------------------------------------------------------------------
// piece_queue_and_stack_unit
// Piece store split into a circular queue and a stack, one operation per item.
// ----------------------------------------------------------------------------
// Busy is high only while reset is held, so after reset a command is taken on
// every cycle that start is high. Each command is registered, executed in the
// next cycle against the queue and stack, and its result is registered onto
// o_result with o_done, one result per command. The rate of one command per
// cycle is set by the single read port of each part's memory: the next head
// and top entries are prefetched at the same edge that updates the pointers,
// with the just-written piece forwarded when it lands on that slot. Results
// cannot be held off; sample them on the cycle o_done is high.
// ----------------------------------------------------------------------------
module piece_queue_and_stack_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  qsu_pkg::t_in    i_item,
    output logic            busy,
    output logic            o_done,
    output qsu_pkg::t_res   o_result
);
    import qsu_pkg::*;

    logic       r_in_valid;
    t_in        r_in;
    logic       r_done;
    t_res       r_res, n_res;

    t_part_ctl  w_qctl, w_sctl;
    t_part_stat w_qstat, w_sstat;
    t_piece     w_qhead, w_stop;
    t_piece     w_qwdata, w_swdata;
    t_piece     w_piece_in;
    t_piece     w_got;
    logic [3:0] w_qcount;
    logic [4:0] w_scount;
    logic [2:0] w_op;

    assign busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    assign w_op             = r_in.opcode;
    assign w_piece_in.shape = r_in.piece_shape;
    assign w_piece_in.color = r_in.piece_color;

    // Part control: a move drops its piece when the destination is full
    always_comb begin
        w_qctl.take = r_in_valid && !w_qstat.empty
                      && ((w_op == OP_DEQ) || (w_op == OP_Q2S));
        w_sctl.take = r_in_valid && !w_sstat.empty
                      && ((w_op == OP_POP) || (w_op == OP_S2Q));
        w_qctl.add  = r_in_valid && !w_qstat.full
                      && ((w_op == OP_ENQ) || ((w_op == OP_S2Q) && !w_sstat.empty));
        w_sctl.add  = r_in_valid && !w_sstat.full
                      && ((w_op == OP_PUSH) || ((w_op == OP_Q2S) && !w_qstat.empty));
        w_qwdata    = (w_op == OP_S2Q) ? w_stop : w_piece_in;
        w_swdata    = (w_op == OP_Q2S) ? w_qhead : w_piece_in;
    end

    always_comb begin
        w_got        = '0;
        n_res.status = ST_OK;
        unique case (w_op)
            OP_ENQ: begin
                if (w_qstat.full) n_res.status = ST_QFULL;
            end
            OP_DEQ: begin
                if (w_qstat.empty) n_res.status = ST_QEMPTY;
                else               w_got        = w_qhead;
            end
            OP_PUSH: begin
                if (w_sstat.full) n_res.status = ST_SFULL;
            end
            OP_POP: begin
                if (w_sstat.empty) n_res.status = ST_SEMPTY;
                else               w_got        = w_stop;
            end
            OP_Q2S: begin
                if (!w_qstat.empty) begin
                    w_got = w_qhead;
                    if (w_sstat.full) n_res.status = ST_SFULL;
                end
            end
            OP_S2Q: begin
                if (!w_sstat.empty) begin
                    w_got = w_stop;
                    if (w_qstat.full) n_res.status = ST_QFULL;
                end
            end
            default: begin
            end
        endcase
        n_res.out_shape   = w_got.shape;
        n_res.out_color   = w_got.color;
        n_res.queue_count = w_qcount;
        n_res.stack_count = w_scount;
    end

    qsu_queue #(
        .SLOTS   (SLOTS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .i_wdata (w_qwdata),
        .o_head  (w_qhead),
        .o_stat  (w_qstat),
        .o_count (w_qcount)
    );

    qsu_stack #(
        .SLOTS   (SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sctl),
        .i_wdata (w_swdata),
        .o_top   (w_stop),
        .o_stat  (w_sstat),
        .o_count (w_scount)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_transfer_gives_result : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done
    ) else $error("transfer produced no result strobe");

    a_result_has_transfer : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2)
    ) else $error("result strobe without a transfer");

    a_empty_read_no_piece : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_result.status == ST_QEMPTY) || (o_result.status == ST_SEMPTY)))
        |-> ((o_result.out_shape == '0) && (o_result.out_color == '0))
    ) else $error("empty read returned a piece");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for piece_queue_and_stack_unit: commands are driven
// through the start/busy handshake, each transfer runs through an in-bench
// model of the queue and stack, and every strobed result is compared field
// by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;
    import qsu_pkg::*;

    localparam int          LIMIT_CYCLES = 100000;
    localparam int          IDLE_PCT     = 22;
    localparam int          TAIL_CYCLES  = 6;
    localparam logic [2:0]  OP_NOP6      = 3'd6;
    localparam logic [2:0]  OP_NOP7      = 3'd7;

    // Fill-biased, drain-biased and mixed random traffic
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    t_in    i_item;
    logic   busy;
    logic   o_done;
    t_res   o_result;

    // Model state
    t_piece     q_mem [SLOTS];
    logic [3:0] q_head  = '0;
    logic [3:0] q_tail  = '0;
    t_piece     s_mem [SLOTS];
    logic [4:0] s_depth = '0;

    t_res   pending_results [$];
    t_res   want_res;
    int     errors = 0;
    int     cycles = 0;
    bit     idle_on = 1'b1;

    piece_queue_and_stack_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Queue and stack model
    // ------------------------------------------------------------------------
    function automatic bit queue_put(input t_piece p);
        if (4'(q_tail + 4'd1) == q_head) return 1'b0;
        q_mem[q_tail] = p;
        q_tail = 4'(q_tail + 4'd1);
        return 1'b1;
    endfunction

    function automatic bit queue_get(output t_piece p);
        p = '0;
        if (q_head == q_tail) return 1'b0;
        p = q_mem[q_head];
        q_head = 4'(q_head + 4'd1);
        return 1'b1;
    endfunction

    function automatic bit stack_put(input t_piece p);
        if (s_depth >= 5'(SLOTS)) return 1'b0;
        s_mem[s_depth[3:0]] = p;
        s_depth = 5'(s_depth + 5'd1);
        return 1'b1;
    endfunction

    function automatic bit stack_get(output t_piece p);
        p = '0;
        if (s_depth == 5'd0) return 1'b0;
        s_depth = 5'(s_depth - 5'd1);
        p = s_mem[s_depth[3:0]];
        return 1'b1;
    endfunction

    function automatic t_res apply_piece_op(input t_in cmd);
        t_res   r;
        t_piece p;
        t_piece got;
        t_piece moved;
        r = '0;
        r.status = ST_OK;
        got = '0;
        p.shape = cmd.piece_shape;
        p.color = cmd.piece_color;
        case (cmd.opcode)
            OP_ENQ: begin
                if (!queue_put(p)) r.status = ST_QFULL;
            end
            OP_DEQ: begin
                if (!queue_get(got)) r.status = ST_QEMPTY;
            end
            OP_PUSH: begin
                if (!stack_put(p)) r.status = ST_SFULL;
            end
            OP_POP: begin
                if (!stack_get(got)) r.status = ST_SEMPTY;
            end
            OP_Q2S: begin
                // a piece moved to a full stack is lost but still reported
                if (queue_get(moved)) begin
                    got = moved;
                    if (!stack_put(moved)) r.status = ST_SFULL;
                end
            end
            OP_S2Q: begin
                if (stack_get(moved)) begin
                    got = moved;
                    if (!queue_put(moved)) r.status = ST_QFULL;
                end
            end
            default: begin
            end
        endcase
        r.out_shape   = got.shape;
        r.out_color   = got.color;
        r.queue_count = 4'(q_tail - q_head);
        r.stack_count = s_depth;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so every strobe is a transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %p", o_result);
                errors++;
            end else begin
                want_res = pending_results.pop_front();
                if (o_result.status !== want_res.status) begin
                    $error("status: expected %0d, got %0d", want_res.status, o_result.status);
                    errors++;
                end
                if (o_result.out_shape !== want_res.out_shape) begin
                    $error("out_shape: expected %h, got %h",
                           want_res.out_shape, o_result.out_shape);
                    errors++;
                end
                if (o_result.out_color !== want_res.out_color) begin
                    $error("out_color: expected %h, got %h",
                           want_res.out_color, o_result.out_color);
                    errors++;
                end
                if (o_result.queue_count !== want_res.queue_count) begin
                    $error("queue_count: expected %0d, got %0d",
                           want_res.queue_count, o_result.queue_count);
                    errors++;
                end
                if (o_result.stack_count !== want_res.stack_count) begin
                    $error("stack_count: expected %0d, got %0d",
                           want_res.stack_count, o_result.stack_count);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    task automatic send_cmd(input t_in cmd);
        t_in noise;
        // Idle cycles are added while a random draw stays under IDLE_PCT, each with the same chance
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            noise = t_in'($urandom);
            start  <= 1'b0;
            i_item <= noise;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_piece_op(cmd));
    endtask

    // Hold off until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in make_cmd(input logic [2:0] op);
        t_in c;
        c = t_in'($urandom);
        c.opcode = op;
        return c;
    endfunction

    function automatic t_in piece_cmd(input logic [2:0] op, input logic [15:0] shape,
                                      input logic [7:0] color);
        t_in c;
        c.opcode      = op;
        c.piece_shape = shape;
        c.piece_color = color;
        return c;
    endfunction

    function automatic t_in random_cmd(input int mode);
        t_in c;
        int  roll;
        c = t_in'($urandom);
        roll = $urandom_range(99);
        if (mode == MODE_FILL) begin
            if (roll < 35)      c.opcode = OP_ENQ;
            else if (roll < 70) c.opcode = OP_PUSH;
            else if (roll < 78) c.opcode = OP_Q2S;
            else if (roll < 86) c.opcode = OP_S2Q;
            else if (roll < 93) c.opcode = OP_DEQ;
            else if (roll < 97) c.opcode = OP_POP;
        end else if (mode == MODE_DRAIN) begin
            if (roll < 35)      c.opcode = OP_DEQ;
            else if (roll < 70) c.opcode = OP_POP;
            else if (roll < 78) c.opcode = OP_Q2S;
            else if (roll < 86) c.opcode = OP_S2Q;
            else if (roll < 93) c.opcode = OP_ENQ;
            else if (roll < 97) c.opcode = OP_PUSH;
        end else begin
            if (roll < 96) c.opcode = 3'($urandom_range(5));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_reads();
        send_cmd(make_cmd(OP_DEQ));
        send_cmd(make_cmd(OP_POP));
        send_cmd(make_cmd(OP_Q2S));
        send_cmd(make_cmd(OP_S2Q));
        send_cmd(make_cmd(OP_NOP6));
        send_cmd(make_cmd(OP_NOP7));
    endtask

    task automatic test_piece_extremes();
        send_cmd(piece_cmd(OP_ENQ,  16'h0000, 8'h00));
        send_cmd(piece_cmd(OP_ENQ,  16'hFFFF, 8'hFF));
        send_cmd(piece_cmd(OP_PUSH, 16'hFFFF, 8'hFF));
        send_cmd(piece_cmd(OP_PUSH, 16'hA5A5, 8'h5A));
        send_cmd(make_cmd(OP_Q2S));
        send_cmd(make_cmd(OP_S2Q));
        send_cmd(make_cmd(OP_DEQ));
        send_cmd(make_cmd(OP_DEQ));
        send_cmd(make_cmd(OP_POP));
        send_cmd(make_cmd(OP_POP));
        send_cmd(make_cmd(OP_POP));
    endtask

    // Fill both parts past capacity, move into full parts, then empty them
    task automatic test_fill_overflow();
        repeat (SLOTS + 1) send_cmd(make_cmd(OP_ENQ));
        repeat (SLOTS + 2) send_cmd(make_cmd(OP_PUSH));
        send_cmd(make_cmd(OP_Q2S));
        send_cmd(make_cmd(OP_ENQ));
        send_cmd(make_cmd(OP_S2Q));
        repeat (SLOTS) send_cmd(make_cmd(OP_DEQ));
        repeat (SLOTS + 1) send_cmd(make_cmd(OP_POP));
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 360; i++) begin
            idle_on = !(i >= 150 && i < 250);
            if (i == 300) drain_results();
            send_cmd(random_cmd((i / 40) % 3));
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_reads();
        test_piece_extremes();
        test_fill_overflow();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== piece_queue_and_stack_unit.f =====
rtl/qsu_pkg.sv
rtl/qsu_queue.sv
rtl/qsu_stack.sv
rtl/piece_queue_and_stack_unit.sv
bench/tb.sv
